// ===== hw/rtl/lned_pkg.sv =====
// Package for the line editor: limits, character codes, queue command and result types.
`default_nettype none
package lned_pkg;

  // Line buffer depth; the editor addresses at most 256 entries.
  localparam int LINE_DEPTH     = 256;
  localparam int LINE_LIMIT_MAX = (LINE_DEPTH < 256) ? LINE_DEPTH : 256;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE     = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_END,
    CMD_ERASE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
    logic [7:0] idx;
    logic       echo;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic [7:0] line_length;
    logic [7:0] write_byte;
    logic [7:0] write_index;
    logic [7:0] echo_byte;
  } res_data_t;

  typedef struct packed {
    logic line_done;
    logic write_valid;
    logic echo_valid;
  } res_user_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lned_cmd_fifo.sv =====
// Short command queue between the classifying front and the expanding back.
`default_nettype none
module lned_cmd_fifo
  import lned_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output cmd_t      head_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lned_front.sv =====
// Front end: config registers, byte classification and line index tracking.
`default_nettype none
module lned_front
  import lned_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  rx_valid_i,
  output logic                       rx_ready_o,
  input  wire logic [7:0]            rx_byte_i,
  output logic                       push_o,
  output cmd_t                       push_data_o,
  input  wire logic                  q_full_i
);

  localparam logic [8:0] LimitMax = 9'(LINE_LIMIT_MAX);

  logic [8:0] max_len_q;
  logic       echo_q;
  logic [7:0] idx_q, idx_d;
  logic [8:0] lim;
  logic [7:0] lim_m1;
  logic [7:0] idx_inc;
  logic       accept;

  assign rx_ready_o = !q_full_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign idx_inc    = idx_q + 8'd1;

  // Clamp the limit to [2, LINE_LIMIT_MAX].
  always_comb begin
    if (max_len_q < 9'd2) begin
      lim = 9'd2;
    end else if (max_len_q > LimitMax) begin
      lim = LimitMax;
    end else begin
      lim = max_len_q;
    end
  end
  assign lim_m1 = 8'(lim - 9'd1);

  always_comb begin
    idx_d            = idx_q;
    push_o           = 1'b0;
    push_data_o      = '0;
    push_data_o.kind = CMD_END;
    push_data_o.ch   = rx_byte_i;
    push_data_o.idx  = idx_q;
    push_data_o.echo = echo_q;
    if (accept) begin
      if (rx_byte_i == CH_LF || rx_byte_i == CH_CR) begin
        push_o           = 1'b1;
        push_data_o.kind = CMD_END;
        idx_d            = '0;
      end else if (rx_byte_i == CH_BS || rx_byte_i == CH_DEL) begin
        if (idx_q != '0) begin
          idx_d            = idx_q - 8'd1;
          push_o           = echo_q;
          push_data_o.kind = CMD_ERASE;
        end
      end else if (idx_q >= lim_m1) begin
        // stale index after a limit shrink: drop the byte, close the line
        push_o           = 1'b1;
        push_data_o.kind = CMD_END;
        idx_d            = '0;
      end else begin
        push_o           = 1'b1;
        push_data_o.kind = CMD_STORE;
        push_data_o.done = (idx_inc >= lim_m1);
        idx_d            = (idx_inc >= lim_m1) ? '0 : idx_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 9'd256;
      echo_q    <= 1'b1;
      idx_q     <= '0;
    end else begin
      idx_q <= idx_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_LINE_LENGTH: max_len_q <= cfg_data_i;
          CFG_ECHO_ENABLE:     echo_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lned_back.sv =====
// Back end: expands queued commands into result transactions through an output register.
`default_nettype none
module lned_back
  import lned_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output res_data_t  out_data_o,
  output res_user_t  out_user_o,
  output logic       out_last_o
);

  logic [1:0] step_q, step_d;
  logic       valid_q, valid_d;
  res_data_t  data_q, data_d;
  res_user_t  user_q, user_d;
  logic       last_q, last_d;
  logic       final_step;
  logic       load;
  logic [7:0] idx_next;

  assign load     = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o    = load && final_step;
  assign idx_next = head_i.idx + 8'd1;

  always_comb begin
    data_d     = '0;
    user_d     = '0;
    last_d     = 1'b1;
    final_step = 1'b1;
    unique case (head_i.kind)
      CMD_STORE: begin
        if (step_q == 2'd0) begin
          user_d.echo_valid  = head_i.echo;
          data_d.echo_byte   = head_i.echo ? head_i.ch : CH_NUL;
          user_d.write_valid = 1'b1;
          data_d.write_index = head_i.idx;
          data_d.write_byte  = head_i.ch;
          last_d             = !head_i.done;
          final_step         = !head_i.done;
        end else begin
          // terminator after the store that filled the line
          user_d.write_valid = 1'b1;
          data_d.write_index = idx_next;
          data_d.write_byte  = CH_NUL;
          user_d.line_done   = 1'b1;
          data_d.line_length = idx_next;
        end
      end
      CMD_END: begin
        user_d.write_valid = 1'b1;
        data_d.write_index = head_i.idx;
        data_d.write_byte  = CH_NUL;
        user_d.line_done   = 1'b1;
        data_d.line_length = head_i.idx;
      end
      CMD_ERASE: begin
        user_d.echo_valid = 1'b1;
        data_d.echo_byte  = (step_q == 2'd1) ? CH_SPACE : CH_BS;
        last_d            = (step_q == 2'd2);
        final_step        = (step_q == 2'd2);
      end
      default: ;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (pop_o) begin
      step_d = '0;
    end else if (load) begin
      step_d = step_q + 2'd1;
    end
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      user_q <= user_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/line_editor_with_echo.sv =====
// Top level of the console line editor with echo.
// A byte's first result passes the command queue and the back end's output register.
// Throughput: one result transaction per cycle from that register while m_axis_tready
//   is high; a byte gives up to 3 results (3 for an echoed erase, 2 for a store
//   that fills the line). Bytes that give no result never reach the queue.
// Reset (async, active low): line index 0, max_line_length 256, echo on, queue empty.
`default_nettype none
module line_editor_with_echo
  import lned_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port: index 0 max_line_length, 1 echo_enable
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // received bytes
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
  // results
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [7:0] echo_byte, [15:8] write_index, [23:16] write_byte, [31:24] line_length
  output logic [31:0]                m_axis_tdata,
  // [0] echo_valid, [1] write_valid, [2] line_done
  output logic [2:0]                 m_axis_tuser,
  output logic                       m_axis_tlast   // last result of the byte
);

  logic      push;
  cmd_t      push_data;
  logic      q_full;
  logic      pop;
  logic      head_valid;
  cmd_t      head;
  res_data_t out_data;
  res_user_t out_user;

  // Front: classifies each byte and owns the line index, so the next byte can
  // be taken while earlier commands still expand in the back.
  lned_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx_valid_i  (s_axis_tvalid),
    .rx_ready_o  (s_axis_tready),
    .rx_byte_i   (s_axis_tdata),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  // Two-entry command queue decouples the front from output stalls.
  lned_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back: one result per command step, one per cycle while m_axis_tready is high.
  lned_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_data),
    .out_user_o   (out_user),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = out_data;
  assign m_axis_tuser = out_user;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the console line editor: directed table, then random phases.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lned_pkg::*;

  // One result transaction as the block presents it: tuser, tdata, tlast.
  typedef struct packed {
    res_user_t user;
    res_data_t data;
    logic      last;
  } console_result_t;

  // A row of the directed table: either a register write or a byte.
  // Rows with a fixed result carry it in want; the rest use the predictor.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [7:0]            rx;
    bit                    fixed;
    console_result_t       want;
  } drill_row_t;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int          HOLD_CYCLES = 200;

  // DUT connections; every input starts at a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;   // echo_byte, write_index, write_byte, line_length
  logic [2:0]            m_axis_tuser;   // echo_valid, write_valid, line_done
  logic                  m_axis_tlast;

  // Predictor state: its own copy of the line index and both registers.
  logic [7:0]            line_pos = 8'd0;
  logic [CFG_DATA_W-1:0] cfg_max_len = 9'd256;
  logic                  cfg_echo = 1'b1;

  // Results still due from the block, oldest first.
  console_result_t       editor_out_q[$];

  int unsigned fail_count = 0;
  int unsigned checked_count = 0;
  int unsigned lines_ended = 0;
  int unsigned cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_served = 1'b0;

  line_editor_with_echo uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic console_result_t result_of(input logic ev, input logic [7:0] eb,
                                                input logic wv, input logic [7:0] wi,
                                                input logic [7:0] wb, input logic ld,
                                                input logic [7:0] ll, input logic lst);
    console_result_t r;
    r.user.echo_valid  = ev;
    r.user.write_valid = wv;
    r.user.line_done   = ld;
    r.data.echo_byte   = eb;
    r.data.write_index = wi;
    r.data.write_byte  = wb;
    r.data.line_length = ll;
    r.last             = lst;
    return r;
  endfunction

  // Terminator at the current index; the length equals the index.
  function automatic void end_line();
    editor_out_q.push_back(result_of(1'b0, CH_NUL, 1'b1, line_pos, CH_NUL, 1'b1,
                                     line_pos, 1'b1));
    line_pos = 8'd0;
    lines_ended++;
  endfunction

  // Queues the results one byte causes; returns their number, or -1 when the
  // byte leaves the editor untouched (erase at line start).
  function automatic int edit_byte(input logic [7:0] c);
    int unsigned lim;
    logic [7:0]  pos;
    lim = cfg_max_len;
    if (lim < 2) lim = 2;
    if (lim > LINE_LIMIT_MAX) lim = LINE_LIMIT_MAX;
    pos = line_pos;
    if (c == CH_LF || c == CH_CR) begin
      end_line();
      return 1;
    end
    if (c == CH_BS || c == CH_DEL) begin
      if (pos == 8'd0) return -1;
      line_pos = pos - 8'd1;
      if (!cfg_echo) return 0;
      // erase sequence: BS, space, BS
      editor_out_q.push_back(result_of(1'b1, CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      editor_out_q.push_back(result_of(1'b1, CH_SPACE, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      editor_out_q.push_back(result_of(1'b1, CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1));
      return 3;
    end
    // index left beyond a shrunken limit: byte dropped, line closed as is
    if (pos >= lim - 1) begin
      end_line();
      return 1;
    end
    editor_out_q.push_back(result_of(cfg_echo, cfg_echo ? c : CH_NUL, 1'b1, pos, c, 1'b0,
                                     8'd0, (pos + 1 < lim - 1)));
    line_pos = pos + 8'd1;
    if (pos + 1 >= lim - 1) begin
      end_line();
      return 2;
    end
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checker
  // ---------------------------------------------------------------------------
  // Ready changes at the falling edge. One long hold-off lets the command
  // queue fill so the input side has to stall.
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Sampled at the rising edge, where the handshake completes.
  always @(posedge clk) begin : result_check
    console_result_t want;
    res_user_t       got_user;
    res_data_t       got_data;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got_user = res_user_t'(m_axis_tuser);
      got_data = res_data_t'(m_axis_tdata);
      if (editor_out_q.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        want = editor_out_q.pop_front();
        checked_count++;
        check_field("echo_valid", want.user.echo_valid, got_user.echo_valid);
        check_field("echo_byte", want.data.echo_byte, got_data.echo_byte);
        check_field("write_valid", want.user.write_valid, got_user.write_valid);
        check_field("write_index", want.data.write_index, got_data.write_index);
        check_field("write_byte", want.data.write_byte, got_data.write_byte);
        check_field("line_done", want.user.line_done, got_user.line_done);
        check_field("line_length", want.data.line_length, got_data.line_length);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------
  // Offers one byte, with a random gap first, and returns at the falling edge
  // after its transaction. tvalid stays high so back-to-back bytes need no
  // second assignment in the same step.
  task automatic offer_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Register writes only with the block drained; a further wait after that
  // covers bytes that gave no result but may still be in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    wait (editor_out_q.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_LINE_LENGTH) cfg_max_len = val;
    else cfg_echo = val[0];
  endtask

  // Mostly printable text; terminators rare in long-line mode so lines fill.
  function automatic logic [7:0] random_console_byte(input bit long_lines);
    int unsigned roll;
    roll = $urandom_range(999);
    if (roll < (long_lines ? 3 : 120)) return $urandom_range(1) ? CH_CR : CH_LF;
    if (roll < (long_lines ? 40 : 220)) return $urandom_range(1) ? CH_BS : CH_DEL;
    if (roll < (long_lines ? 80 : 320)) return 8'($urandom_range(255));
    return 8'($urandom_range(126, 32));
  endfunction

  function automatic drill_row_t row_byte(input logic [7:0] rx);
    drill_row_t r;
    r = '{default: '0};
    r.rx = rx;
    return r;
  endfunction

  function automatic drill_row_t row_fixed(input logic [7:0] rx, input console_result_t want);
    drill_row_t r;
    r = row_byte(rx);
    r.fixed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic drill_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    drill_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Watchdog on the cycle counter.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cycle_count,
             editor_out_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    drill_row_t            drills[$];
    int                    base;
    int                    n;
    int                    count;
    int                    seg_items;
    int                    bytes_sent;
    int                    directed_bytes;
    bit                    paused;
    logic [7:0]            b;
    logic [CFG_DATA_W-1:0] seg_len;
    logic                  seg_echo;

    bytes_sent = 0;
    directed_bytes = 0;
    paused = 1'b0;

    // Directed table. Fixed results: terminator and first store right after
    // reset, and the dropped byte when the limit shrinks under the index.
    drills = '{
      row_fixed(CH_CR, result_of(1'b0, 8'd0, 1'b1, 8'd0, CH_NUL, 1'b1, 8'd0, 1'b1)),
      row_fixed(8'h41, result_of(1'b1, 8'h41, 1'b1, 8'd0, 8'h41, 1'b0, 8'd0, 1'b1)),
      row_byte(8'h00), row_byte(8'hFF),            // field extremes stored
      row_byte(CH_BS), row_byte(CH_DEL), row_byte(CH_DEL),
      row_byte(CH_BS),                             // erase at line start: ignored
      row_byte(CH_LF),
      row_cfg(CFG_ECHO_ENABLE, 9'd0),
      row_byte("x"), row_byte(CH_BS),              // silent erase
      row_byte("y"), row_byte(CH_CR),
      row_cfg(CFG_MAX_LINE_LENGTH, 9'd3), row_cfg(CFG_ECHO_ENABLE, 9'd1),
      row_byte("a"), row_byte("b"),                // second store fills the line
      row_cfg(CFG_MAX_LINE_LENGTH, 9'd0),          // clamps up to 2
      row_byte("c"),
      row_cfg(CFG_MAX_LINE_LENGTH, 9'd511),        // clamps down to the depth
      row_byte("d"), row_byte("e"), row_byte("f"),
      row_cfg(CFG_MAX_LINE_LENGTH, 9'd2),          // index now beyond the limit
      row_fixed("g", result_of(1'b0, 8'd0, 1'b1, 8'd3, CH_NUL, 1'b1, 8'd3, 1'b1)),
      row_cfg(CFG_MAX_LINE_LENGTH, 9'd1),
      row_byte("h"),
      row_cfg(CFG_MAX_LINE_LENGTH, 9'd256),
      row_byte(8'h7E), row_byte(CH_CR)
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part runs with the sender idling 13% and receiver 67%
    tx_idle_pct = 13;
    rx_idle_pct = 67;
    foreach (drills[i]) begin
      if (drills[i].is_cfg) begin
        write_reg(drills[i].reg_idx, drills[i].reg_val);
      end else begin
        offer_byte(drills[i].rx);
        base = editor_out_q.size();
        n = edit_byte(drills[i].rx);
        if (drills[i].fixed) editor_out_q[base] = drills[i].want;
        directed_bytes++;
      end
    end

    // Random part: six segments, two per idle profile, each with its own
    // register settings. The last uses a mid-size limit and few terminators
    // so lines run long and fill.
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 67;
        end
        1: begin
          tx_idle_pct = 67;
          rx_idle_pct = 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (seg)
        0: begin
          seg_len = 9'd256;
          seg_echo = 1'b1;
        end
        1: begin
          seg_len = 9'd2;
          seg_echo = 1'b0;
        end
        2: begin
          seg_len = 9'($urandom_range(40, 3));
          seg_echo = 1'b1;
        end
        3: begin
          seg_len = 9'd511;
          seg_echo = 1'($urandom_range(1));
        end
        4: begin
          seg_len = 9'($urandom_range(1));
          seg_echo = 1'b1;
        end
        default: begin
          seg_len = 9'd200;
          seg_echo = 1'($urandom_range(1));
        end
      endcase
      write_reg(CFG_MAX_LINE_LENGTH, seg_len);
      write_reg(CFG_ECHO_ENABLE, 9'(seg_echo));
      if (seg == 1) hold_req = 1'b1;   // receiver blocks while bytes keep coming
      seg_items = (seg == 5) ? 240 : 40;
      count = 0;
      while (count < seg_items) begin
        // sender waits once for the block to drain completely
        if (seg == 3 && count == 20 && !paused) begin
          paused = 1'b1;
          s_axis_tvalid <= 1'b0;
          wait (editor_out_q.size() == 0);
          @(negedge clk);
        end
        b = random_console_byte(seg == 5);
        offer_byte(b);
        n = edit_byte(b);
        bytes_sent++;
        if (n >= 0) count++;
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (editor_out_q.size() == 0);
    repeat (8) @(negedge clk);

    $display("Covered %0d directed and %0d random bytes, %0d results checked, %0d lines ended.",
             directed_bytes, bytes_sent, checked_count, lines_ended);
    $display("Limits 0 to 511 with clamping, echo on and off, three idle profiles, long stall.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== line_editor_with_echo.f =====
hw/rtl/lned_pkg.sv
hw/rtl/lned_cmd_fifo.sv
hw/rtl/lned_front.sv
hw/rtl/lned_back.sv
hw/rtl/line_editor_with_echo.sv
sim/testbench.sv
